### hdl/ppm_pulse_train_decoder_top_macros.svh
// ---------------------------------------------------------------------------
// PPM decoder assertion macros
// Shorthand for the clocked, reset-qualified assertions in the checker.
// ---------------------------------------------------------------------------
`ifndef PPM_PULSE_TRAIN_DECODER_TOP_MACROS_SVH
`define PPM_PULSE_TRAIN_DECODER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PPMD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PPMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ppmd_pkg.sv
// ---------------------------------------------------------------------------
// PPM decoder package
// Widths, reset values, state codes and the divider interface types.
// ---------------------------------------------------------------------------
package ppmd_pkg;

   // Timer capture width and the width of a measured pulse.
   localparam int unsigned TS_W     = 24;
   localparam int unsigned WIDTH_W  = 16;

   localparam int unsigned THR_W    = 16;
   localparam int unsigned COUNT_W  = 4;
   localparam int unsigned CHAN_W   = 3;
   localparam int unsigned FRAME_W  = 32;
   localparam int unsigned RESYNC_W = 16;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 24;

   localparam logic [TS_W-1:0]    PERIOD_RESET    = 24'hFF_FFFF;
   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 16'd3000;
   localparam logic [COUNT_W-1:0] COUNT_RESET     = 4'd7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMER_PERIOD,
      CSR_FRAME_THRESHOLD,
      CSR_CHANNEL_COUNT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_WRAP,
      ST_CMP,
      ST_DIVGO,
      ST_DIVWAIT,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_GAP,
      PH_LOCKED
   } phase_type;

   typedef struct packed {
      logic            start;
      logic [TS_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [WIDTH_W-1:0] quotient;
   } div_rsp_type;

endpackage

### hdl/ppm_pulse_train_decoder_top.sv
// ---------------------------------------------------------------------------
// PPM pulse-train decoder
// Measures pulse widths from timer captures and emits whole frames.
// ---------------------------------------------------------------------------
// Each request carries one captured edge. A falling edge, and the first
// rising edge after reset or a resync, is taken without leaving the idle
// state, and the block is ready again in the next cycle. Any other rising
// edge keeps the block busy after it is taken: the span, wrap and compare
// states measure the span since the last rise and the low time since the
// last fall (with timer wrap) and check their order, then the divider,
// which multiplies by a fixed reciprocal of the clock rate, scales and
// saturates the product and hands back the microseconds, and last the
// update state tracks the frame. Edges in an impossible order end after
// the order check, and a span that is still negative after the wrap
// correction saturates without the divider. When a frame completes, the
// block sends one response per channel, one per cycle while the response
// side is ready, and takes the next request once the last response of the
// frame is loaded into the output register. The time for one request is
// therefore set by the measurement sequence plus, at frame end, the
// channel responses and any response stall.
// Configuration writes are accepted on any cycle and take effect at once;
// they should only be issued while the block is idle.
module ppm_pulse_train_decoder_top #(
   parameter int unsigned MAX_CHANNELS  = 8,
   parameter int unsigned CYCLES_PER_US = 80
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_edge_rising,
   input  logic [ppmd_pkg::TS_W-1:0]            req_timestamp,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ppmd_pkg::CHAN_W-1:0]          rsp_channel,
   output logic [ppmd_pkg::WIDTH_W-1:0]         rsp_width_us,
   output logic [ppmd_pkg::FRAME_W-1:0]         rsp_frame_number,
   output logic [ppmd_pkg::RESYNC_W-1:0]        rsp_resync_total,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ppmd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppmd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ppmd_pkg::*;

   localparam int unsigned CIDX_W = $clog2(MAX_CHANNELS + 1);

   // Configuration registers.
   logic [TS_W-1:0]     timer_period_ff, timer_period_in;
   logic [THR_W-1:0]    frame_threshold_ff, frame_threshold_in;
   logic [COUNT_W-1:0]  channel_count_ff, channel_count_in;

   // Control state.
   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic                rise_valid_ff, rise_valid_in;
   logic [TS_W-1:0]     rise_time_ff, rise_time_in;
   logic [TS_W-1:0]     fall_time_ff, fall_time_in;
   logic [CIDX_W-1:0]   chan_idx_ff, chan_idx_in;
   logic [CIDX_W-1:0]   emit_idx_ff, emit_idx_in;
   logic [FRAME_W-1:0]  frame_count_ff, frame_count_in;
   logic [RESYNC_W-1:0] resync_count_ff, resync_count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Measurement datapath.
   logic [TS_W-1:0]     now_ff, now_in;
   logic [TS_W:0]       span_ff, span_in;
   logic [TS_W:0]       low_ff, low_in;
   logic [TS_W-1:0]     cycles_ff, cycles_in;
   logic [WIDTH_W-1:0]  w_ff, w_in;

   // Output register payload.
   logic [CHAN_W-1:0]   rsp_channel_ff, rsp_channel_in;
   logic [WIDTH_W-1:0]  rsp_width_ff, rsp_width_in;
   logic [FRAME_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic [RESYNC_W-1:0] rsp_resync_ff, rsp_resync_in;
   logic                rsp_last_ff, rsp_last_in;

   // Width store: one entry per channel plus the frame gap.
   logic [WIDTH_W-1:0]  width_store_ff [MAX_CHANNELS + 1];
   logic                store_we;
   logic [CIDX_W-1:0]   store_addr;

   logic [CIDX_W-1:0]   n_chan;
   logic [CIDX_W-1:0]   widx;
   logic [CIDX_W-1:0]   next_idx;
   logic                above;
   logic                slip;
   logic [TS_W+1:0]     diff;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   ppmd_div #(
      .DIVISOR (CYCLES_PER_US)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   // Channel counts above MAX_CHANNELS saturate to it.
   assign n_chan = (32'(channel_count_ff) > 32'(MAX_CHANNELS)) ?
                   CIDX_W'(MAX_CHANNELS) : CIDX_W'(channel_count_ff);

   assign div_req.start    = (state_ff == ST_DIVGO);
   assign div_req.dividend = cycles_ff;

   always_comb begin
      timer_period_in    = timer_period_ff;
      frame_threshold_in = frame_threshold_ff;
      channel_count_in   = channel_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIMER_PERIOD:    timer_period_in    = csr_wdata[TS_W-1:0];
            CSR_FRAME_THRESHOLD: frame_threshold_in = csr_wdata[THR_W-1:0];
            CSR_CHANNEL_COUNT:   channel_count_in   = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      rise_valid_in   = rise_valid_ff;
      rise_time_in    = rise_time_ff;
      fall_time_in    = fall_time_ff;
      chan_idx_in     = chan_idx_ff;
      emit_idx_in     = emit_idx_ff;
      frame_count_in  = frame_count_ff;
      resync_count_in = resync_count_ff;
      now_in          = now_ff;
      span_in         = span_ff;
      low_in          = low_ff;
      cycles_in       = cycles_ff;
      w_in            = w_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_channel_in  = rsp_channel_ff;
      rsp_width_in    = rsp_width_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_resync_in   = rsp_resync_ff;
      rsp_last_in     = rsp_last_ff;
      store_we        = 1'b0;

      // The gap after lock restarts the channel count from zero.
      widx     = (phase_ff == PH_GAP) ? '0 : chan_idx_ff;
      store_addr = widx;
      above    = (w_ff > frame_threshold_ff);
      next_idx = widx;
      slip     = 1'b0;
      diff     = {1'b0, span_ff} - {1'b0, low_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_edge_rising) begin
                  fall_time_in = req_timestamp;
               end else if (!rise_valid_ff) begin
                  rise_time_in  = req_timestamp;
                  rise_valid_in = 1'b1;
               end else begin
                  now_in   = req_timestamp;
                  state_in = ST_SPAN;
               end
            end
         end
         ST_SPAN: begin
            // Raw differences; the top bit flags a timer wrap.
            span_in  = {1'b0, now_ff} - {1'b0, rise_time_ff};
            low_in   = {1'b0, now_ff} - {1'b0, fall_time_ff};
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            // A wrapped difference adds one timer period. A result that is
            // still negative keeps its sign bit and compares as very large.
            if (span_ff[TS_W]) begin
               span_in = span_ff + {1'b0, timer_period_ff};
            end
            if (low_ff[TS_W]) begin
               low_in = low_ff + {1'b0, timer_period_ff};
            end
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (diff[TS_W+1]) begin
               // Low time longer than the rise-to-rise span: edges out of order.
               rise_valid_in   = 1'b0;
               resync_count_in = resync_count_ff + RESYNC_W'(1);
               state_in        = ST_IDLE;
            end else if (span_ff[TS_W] && !low_ff[TS_W]) begin
               w_in     = '1;
               state_in = ST_UPDATE;
            end else begin
               cycles_in = diff[TS_W-1:0];
               state_in  = ST_DIVGO;
            end
         end
         ST_DIVGO: begin
            state_in = ST_DIVWAIT;
         end
         ST_DIVWAIT: begin
            if (div_rsp.done) begin
               w_in     = div_rsp.quotient;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
            if (phase_ff == PH_HUNT) begin
               // Hunting: wait for a pulse long enough to be the frame gap.
               if (above) begin
                  phase_in = PH_GAP;
               end
               rise_time_in = now_ff;
            end else begin
               phase_in = PH_LOCKED;
               store_we = 1'b1;
               if (above) begin
                  if (widx != n_chan) begin
                     slip = 1'b1;
                  end else begin
                     next_idx = '0;
                  end
               end else begin
                  if (widx >= n_chan) begin
                     slip = 1'b1;
                  end else begin
                     next_idx = widx + CIDX_W'(1);
                  end
               end
               chan_idx_in = next_idx;
               if (slip) begin
                  rise_valid_in   = 1'b0;
                  resync_count_in = resync_count_ff + RESYNC_W'(1);
               end else begin
                  rise_time_in = now_ff;
                  if (next_idx == n_chan) begin
                     frame_count_in = frame_count_ff + FRAME_W'(1);
                     emit_idx_in    = '0;
                     if (n_chan != '0) begin
                        state_in = ST_EMIT;
                     end
                  end
               end
            end
         end
         ST_EMIT: begin
            // One channel per cycle into the output register while it is empty or its response is taken.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_channel_in = CHAN_W'(emit_idx_ff);
               rsp_width_in   = width_store_ff[emit_idx_ff];
               rsp_frame_in   = frame_count_ff;
               rsp_resync_in  = resync_count_ff;
               rsp_last_in    = (emit_idx_ff == n_chan - CIDX_W'(1));
               if (emit_idx_ff == n_chan - CIDX_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + CIDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_period_ff    <= PERIOD_RESET;
         frame_threshold_ff <= THRESHOLD_RESET;
         channel_count_ff   <= COUNT_RESET;
         state_ff           <= ST_IDLE;
         phase_ff           <= PH_HUNT;
         rise_valid_ff      <= 1'b0;
         rise_time_ff       <= '0;
         fall_time_ff       <= '0;
         chan_idx_ff        <= '0;
         emit_idx_ff        <= '0;
         frame_count_ff     <= '0;
         resync_count_ff    <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         timer_period_ff    <= timer_period_in;
         frame_threshold_ff <= frame_threshold_in;
         channel_count_ff   <= channel_count_in;
         state_ff           <= state_in;
         phase_ff           <= phase_in;
         rise_valid_ff      <= rise_valid_in;
         rise_time_ff       <= rise_time_in;
         fall_time_ff       <= fall_time_in;
         chan_idx_ff        <= chan_idx_in;
         emit_idx_ff        <= emit_idx_in;
         frame_count_ff     <= frame_count_in;
         resync_count_ff    <= resync_count_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      span_ff        <= span_in;
      low_ff         <= low_in;
      cycles_ff      <= cycles_in;
      w_ff           <= w_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_width_ff   <= rsp_width_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_resync_ff  <= rsp_resync_in;
      rsp_last_ff    <= rsp_last_in;
      if (store_we) begin
         width_store_ff[store_addr] <= w_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_width_us     = rsp_width_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_resync_total = rsp_resync_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

### hdl/ppmd_div.sv
// ---------------------------------------------------------------------------
// PPM decoder divider
// Reciprocal multiplier turning timer cycles into microseconds, saturated.
// ---------------------------------------------------------------------------
module ppmd_div #(
   parameter int unsigned DIVISOR = 80
) (
   input  logic                clock,
   input  logic                reset,
   input  ppmd_pkg::div_req_type div_req,
   output ppmd_pkg::div_rsp_type div_rsp
);
   import ppmd_pkg::*;

   // Rounded-up reciprocal; exact for every dividend of TS_W bits.
   localparam int unsigned        RECIP_W  = TS_W + 2;
   localparam int unsigned        PROD_W   = TS_W + RECIP_W;
   localparam int unsigned        SHIFT    = TS_W + $clog2(DIVISOR);
   localparam logic [63:0]        RECIP_64 = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) /
                                             64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP    = RECIP_64[RECIP_W-1:0];

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [WIDTH_W-1:0] acc_ff, acc_in;
   logic               over;

   always_comb begin
      // Any bit above the quotient field means 2^16 or more.
      over    = |(prod_ff >> (SHIFT + WIDTH_W));
      busy_in = 1'b0;
      done_in = 1'b0;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (div_req.start) begin
         prod_in = PROD_W'(div_req.dividend) * PROD_W'(RECIP);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = over ? '1 : prod_ff[SHIFT +: WIDTH_W];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = acc_ff;

endmodule

### hdl/ppmd_checker.sv
// ---------------------------------------------------------------------------
// PPM decoder checker
// Port-level assertions on the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "ppm_pulse_train_decoder_top_macros.svh"

module ppmd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_edge_rising,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ppmd_pkg::CHAN_W-1:0]     rsp_channel,
   input logic [ppmd_pkg::WIDTH_W-1:0]    rsp_width_us,
   input logic [ppmd_pkg::FRAME_W-1:0]    rsp_frame_number,
   input logic                            rsp_last
);
   import ppmd_pkg::*;

   // A stalled response keeps its contents.
   `PPMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_width_us) && $stable(rsp_channel), "response changed while stalled")

   // Within a frame the next channel follows without a gap.
   `PPMD_ASSERT_NEXT(a_frame_burst, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid && (rsp_frame_number == $past(rsp_frame_number)) && (rsp_channel == CHAN_W'($past(rsp_channel) + 3'd1)), "frame burst broken")

   // No request is taken while a frame is still being sent.
   `PPMD_ASSERT_SAME(a_busy_in_frame, clock, reset, rsp_valid && !rsp_last, !req_ready, "request accepted during frame output")

   // A falling edge only records its time.
   `PPMD_ASSERT_NEXT(a_fall_quick, clock, reset, req_valid && req_ready && !req_edge_rising, req_ready, "falling edge kept the block busy")

endmodule

bind ppm_pulse_train_decoder_top ppmd_checker u_checker (.*);

### dv/ppm_pulse_train_decoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PPM pulse-train decoder testbench
// Feeds captured timer edges into the decoder, predicts every frame that it
// should emit and checks each response field by field.
// ---------------------------------------------------------------------------
// The stimulus opens with a short directed train: edges at the timestamp
// extremes, zero and exact-threshold widths, a low time of zero, a saturated
// frame gap, a misplaced long pulse, two rises without a fall between them
// and a short pulse where the gap belongs. The rest is random traffic,
// mostly well-formed frames with random widths and some corruption, across
// several register settings: threshold and channel count at both ends,
// counts above the channel limit and zero, and a short timer period that
// makes timestamps wrap often.
module tb;
   import ppmd_pkg::*;

   localparam int unsigned MAX_CH        = 8;
   localparam int unsigned US_CYCLES     = 80;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned HOLD_CYCLES   = 600;
   localparam int unsigned STALL_LIMIT   = 4000;

   typedef struct packed {
      logic            rising;
      logic [TS_W-1:0] stamp;
   } capture_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [WIDTH_W-1:0]  width_us;
      logic [FRAME_W-1:0]  frame_number;
      logic [RESYNC_W-1:0] resync_total;
      logic                last;
   } channel_width_type;

   // Every input of the decoder holds a known value from time zero.
   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_ready;
   logic                   req_edge_rising = 1'b0;
   logic [TS_W-1:0]        req_timestamp   = '0;
   logic                   rsp_valid;
   logic                   rsp_ready       = 1'b0;
   logic [CHAN_W-1:0]      rsp_channel;
   logic [WIDTH_W-1:0]     rsp_width_us;
   logic [FRAME_W-1:0]     rsp_frame_number;
   logic [RESYNC_W-1:0]    rsp_resync_total;
   logic                   rsp_last;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index       = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata       = '0;

   always #5 clock = ~clock;

   ppm_pulse_train_decoder_top #(
      .MAX_CHANNELS (MAX_CH),
      .CYCLES_PER_US(US_CYCLES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_edge_rising (req_edge_rising),
      .req_timestamp   (req_timestamp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_channel     (rsp_channel),
      .rsp_width_us    (rsp_width_us),
      .rsp_frame_number(rsp_frame_number),
      .rsp_resync_total(rsp_resync_total),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // -----------------------------------------------------------------------
   // Decoder prediction. The register copies change only when a write is
   // accepted, which happens while the decoder is idle.
   // -----------------------------------------------------------------------
   logic [TS_W-1:0]     cfg_period    = PERIOD_RESET;
   logic [THR_W-1:0]    cfg_threshold = THRESHOLD_RESET;
   logic [COUNT_W-1:0]  cfg_count     = COUNT_RESET;

   logic [TS_W-1:0]     last_rise   = '0;
   logic                rise_known  = 1'b0;
   logic [TS_W-1:0]     last_fall   = '0;
   phase_type           lock_phase  = PH_HUNT;
   int unsigned         slot        = 0;
   logic [WIDTH_W-1:0]  stored_width [MAX_CH+1];
   logic [FRAME_W-1:0]  frames_done = '0;
   logic [RESYNC_W-1:0] resyncs     = '0;

   channel_width_type expected_channels[$];
   capture_type       pending_edges[$];
   int unsigned       failures = 0;

   // Timer cycles from earlier to later. A backward step is taken modulo the
   // period; the arithmetic is 64-bit unsigned, so a stamp beyond the period
   // gives a huge span rather than a small one.
   function automatic logic [63:0] timer_span(input logic [63:0] later,
                                              input logic [63:0] earlier);
      if (later >= earlier)
         return later - earlier;
      return later + 64'(cfg_period) - earlier;
   endfunction

   task automatic lose_sync();
      rise_known = 1'b0;
      resyncs    = resyncs + RESYNC_W'(1);
   endtask

   task automatic decode_edge(input logic rising, input logic [TS_W-1:0] stamp);
      logic [63:0]        span;
      logic [63:0]        low_time;
      logic [63:0]        usec;
      logic [WIDTH_W-1:0] width;
      int unsigned        n;
      channel_width_type  entry;
      n = (32'(cfg_count) > MAX_CH) ? MAX_CH : 32'(cfg_count);
      if (!rising) begin
         last_fall = stamp;
         return;
      end
      // The first rise after reset or a resync only sets the reference.
      if (!rise_known) begin
         last_rise  = stamp;
         rise_known = 1'b1;
         return;
      end
      span     = timer_span(stamp, last_rise);
      low_time = timer_span(stamp, last_fall);
      // A low time longer than the whole period between rises means the
      // edges came in an impossible order.
      if (span < low_time) begin
         lose_sync();
         return;
      end
      usec  = (span - low_time) / US_CYCLES;
      width = (usec > 64'hFFFF) ? '1 : usec[WIDTH_W-1:0];
      if (lock_phase == PH_HUNT) begin
         if (width > cfg_threshold)
            lock_phase = PH_GAP;
         last_rise = stamp;
         return;
      end
      if (lock_phase == PH_GAP) begin
         lock_phase = PH_LOCKED;
         slot       = 0;
      end
      if (slot <= MAX_CH)
         stored_width[slot] = width;
      // A gap is only legal once every channel is in; a channel only before.
      if (width > cfg_threshold) begin
         if (slot != n) begin
            lose_sync();
            return;
         end
         slot = 0;
      end else begin
         if (slot >= n) begin
            lose_sync();
            return;
         end
         slot++;
      end
      last_rise = stamp;
      if (slot != n)
         return;
      frames_done++;
      for (int unsigned k = 0; k < n; k++) begin
         entry.channel      = CHAN_W'(k);
         entry.width_us     = stored_width[k];
         entry.frame_number = frames_done;
         entry.resync_total = resyncs;
         entry.last         = (k + 1 == n);
         expected_channels.push_back(entry);
      end
   endtask

   // -----------------------------------------------------------------------
   // Edge generation. The cursor is the time of the last rise that was queued;
   // a pulse is a fall after its high time and a rise after its low time.
   // -----------------------------------------------------------------------
   longint unsigned edge_cursor  = 0;
   int unsigned     edges_queued = 0;
   int unsigned     edges_taken  = 0;

   task automatic push_edge(input logic rising, input logic [TS_W-1:0] stamp);
      capture_type item;
      item.rising = rising;
      item.stamp  = stamp;
      pending_edges.push_back(item);
      edges_queued++;
      if (rising)
         edge_cursor = stamp;
   endtask

   task automatic push_pulse(input longint unsigned high, input longint unsigned low);
      push_edge(1'b0, TS_W'((edge_cursor + high) % cfg_period));
      push_edge(1'b1, TS_W'((edge_cursor + high + low) % cfg_period));
   endtask

   // Keeps one pulse well inside the timer period so that wrap stays legal.
   function automatic longint unsigned clip_to_period(input longint unsigned cycles);
      longint unsigned cap;
      cap = cfg_period / 2;
      return (cycles > cap) ? cap : cycles;
   endfunction

   function automatic longint unsigned gap_cycles();
      longint unsigned usec;
      usec = 64'(cfg_threshold) + 1 + $urandom_range(1500);
      if ($urandom_range(15) == 0)
         usec = 66000 + $urandom_range(5000);
      return clip_to_period(usec * US_CYCLES + $urandom_range(US_CYCLES - 1));
   endfunction

   function automatic longint unsigned channel_cycles();
      longint unsigned usec;
      usec = $urandom_range(cfg_threshold);
      if ($urandom_range(9) == 0)
         usec = cfg_threshold;
      return clip_to_period(usec * US_CYCLES + $urandom_range(US_CYCLES - 1));
   endfunction

   function automatic longint unsigned low_cycles(input int unsigned max_low_us);
      return clip_to_period($urandom_range(max_low_us * US_CYCLES));
   endfunction

   // Mostly whole frames with random widths; now and then a stray edge, a
   // long pulse in a channel slot, a dropped channel or a second rise.
   task automatic add_traffic(input int unsigned budget, input int unsigned chans,
                              input int unsigned max_low_us);
      int unsigned goal;
      int unsigned roll;
      goal = edges_queued + budget;
      while (edges_queued < goal) begin
         if ($urandom_range(99) < 8) begin
            push_edge(1'($urandom_range(1)), TS_W'($urandom()));
         end else begin
            push_pulse(gap_cycles(), low_cycles(max_low_us));
            for (int unsigned c = 0; c < chans; c++) begin
               roll = $urandom_range(99);
               if (roll < 3)
                  push_pulse(gap_cycles(), low_cycles(max_low_us));
               else if (roll < 5)
                  continue;
               else if (roll < 7)
                  push_edge(1'b1, TS_W'((edge_cursor + $urandom_range(4000)) % cfg_period));
               else
                  push_pulse(channel_cycles(), low_cycles(max_low_us));
            end
         end
      end
   endtask

   // -----------------------------------------------------------------------
   // Register writes. Valid stays high from one write to the next and drops
   // after the last one, so it never sees two assignments in one step.
   // -----------------------------------------------------------------------
   task automatic write_register(input csr_index_type which,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (which)
         CSR_TIMER_PERIOD:    cfg_period    = value[TS_W-1:0];
         CSR_FRAME_THRESHOLD: cfg_threshold = value[THR_W-1:0];
         CSR_CHANNEL_COUNT:   cfg_count     = value[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // The unused upper data bits carry random values; only the low bits count.
   task automatic program_decoder(input logic [TS_W-1:0] period,
                                  input logic [THR_W-1:0] threshold,
                                  input logic [COUNT_W-1:0] count);
      write_register(CSR_TIMER_PERIOD, period);
      write_register(CSR_FRAME_THRESHOLD, {8'($urandom()), threshold});
      write_register(CSR_CHANNEL_COUNT, {20'($urandom()), count});
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued request is taken and every predicted response
   // has arrived, then lets a rising edge with no response finish its work.
   task automatic settle_decoder();
      while (edges_taken != edges_queued || expected_channels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [TS_W-1:0] period,
                            input logic [THR_W-1:0] threshold,
                            input logic [COUNT_W-1:0] count,
                            input int unsigned budget, input int unsigned chans,
                            input int unsigned max_low_us);
      program_decoder(period, threshold, count);
      add_traffic(budget, chans, max_low_us);
      settle_decoder();
   endtask

   // -----------------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps. A
   // request that is not yet taken stays on the port unchanged. The
   // prediction runs at the edge where the decoder accepts the request.
   // -----------------------------------------------------------------------
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   capture_type next_edge;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_edge(req_edge_rising, req_timestamp);
            edges_taken++;
         end
         if (req_valid && !req_ready) begin
            // Hold the current request.
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_edges.size() != 0) begin
            next_edge        = pending_edges.pop_front();
            req_valid       <= 1'b1;
            req_edge_rising <= next_edge.rising;
            req_timestamp   <= next_edge.stamp;
            if (burst_left != 0)
               burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -----------------------------------------------------------------------
   // Response side: ready follows a rotating stall pattern that is redrawn
   // as it ages, sometimes as all ones. Once, after the first few responses,
   // it holds off for a long stretch while requests keep coming, so the
   // decoder fills up and stops taking requests.
   // -----------------------------------------------------------------------
   logic [15:0] stall_pattern  = 16'hFFFF;
   int unsigned pattern_age    = 0;
   int unsigned hold_left      = 0;
   bit          held_once      = 1'b0;
   int unsigned responses_seen = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!held_once && responses_seen >= 20) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready    <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            pattern_age++;
            if (pattern_age % 200 == 0)
               stall_pattern = ($urandom_range(3) == 0) ? 16'hFFFF
                                                        : (16'($urandom()) | 16'h0101);
         end
      end
   end

   // -----------------------------------------------------------------------
   // Response checker: each accepted response against the oldest prediction.
   // -----------------------------------------------------------------------
   channel_width_type want;

   task automatic check_field(input string what, input logic [31:0] wanted,
                              input logic [31:0] seen);
      if (seen !== wanted) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, wanted, seen);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (expected_channels.size() == 0) begin
            $display("%0t: unexpected response: expected none, got channel %0d width %0d",
                     $time, rsp_channel, rsp_width_us);
            failures++;
         end else begin
            want = expected_channels.pop_front();
            check_field("channel", 32'(want.channel), 32'(rsp_channel));
            check_field("width_us", 32'(want.width_us), 32'(rsp_width_us));
            check_field("frame_number", want.frame_number, rsp_frame_number);
            check_field("resync_total", 32'(want.resync_total), 32'(rsp_resync_total));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // Ends the run when no request, response or register write has been
   // accepted for far longer than the slowest correct run ever needs.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // -----------------------------------------------------------------------
   // Test sequence.
   // -----------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed train with two channels per frame.
      program_decoder(PERIOD_RESET, THRESHOLD_RESET, 4'd2);
      push_edge(1'b0, '0);
      push_edge(1'b1, '1);
      // The gap measured across the timer wrap locks the decoder.
      push_pulse(4000 * US_CYCLES, 400 * US_CYCLES);
      push_pulse(0, 300 * US_CYCLES);
      push_pulse(3000 * US_CYCLES + US_CYCLES - 1, 0);
      // Gap wide enough to saturate, then a long pulse in a channel slot.
      push_pulse(70000 * US_CYCLES, 500 * US_CYCLES);
      push_pulse(1000 * US_CYCLES, 300 * US_CYCLES);
      push_pulse(5000 * US_CYCLES, 300 * US_CYCLES);
      // New reference, then a second rise with no fall before it.
      push_pulse(900 * US_CYCLES, 300 * US_CYCLES);
      push_edge(1'b1, TS_W'((edge_cursor + 1000) % cfg_period));
      push_pulse(100 * US_CYCLES, 300 * US_CYCLES);
      push_pulse(1500 * US_CYCLES, 300 * US_CYCLES);
      // A short pulse where the frame gap belongs.
      push_pulse(200 * US_CYCLES, 300 * US_CYCLES);
      settle_decoder();

      // Random traffic over a range of register settings. The sender pauses
      // at every phase boundary until all responses are in.
      run_phase(PERIOD_RESET, THRESHOLD_RESET, COUNT_RESET, 90, 7, 600);
      run_phase(PERIOD_RESET, 16'd1500, 4'd8, 70, 8, 400);
      run_phase(PERIOD_RESET, 16'd0, 4'd2, 40, 2, 300);
      run_phase(PERIOD_RESET, 16'd800, 4'd15, 50, 8, 200);
      run_phase(PERIOD_RESET, 16'd500, 4'd0, 30, 0, 300);
      run_phase(PERIOD_RESET, 16'hFFFF, 4'd1, 20, 1, 300);
      run_phase(24'd40000, 16'd100, 4'd2, 60, 2, 50);
      run_phase(24'd1, THRESHOLD_RESET, 4'd4, 20, 4, 300);
      run_phase(PERIOD_RESET, 16'd2000, 4'd5, 40, 5, 400);

      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/ppmd_pkg.sv
hdl/ppmd_div.sv
hdl/ppm_pulse_train_decoder_top.sv
hdl/ppmd_checker.sv
dv/ppm_pulse_train_decoder_tb.sv
